// File: rtl/ttsg_pkg.sv
`default_nettype none
package ttsg_pkg;

  localparam int MaxPoints   = 1024;
  localparam int MaxContours = 128;
  localparam int PtW  = $clog2(MaxPoints);
  localparam int CtW  = $clog2(MaxContours);
  localparam int PcW  = PtW + 1;
  localparam int CcW  = CtW + 1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_COMPOUND = 3'd2;
  localparam logic [2:0] ST_TOOLARGE = 3'd3;
  localparam logic [2:0] ST_NOPOINT  = 3'd4;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_HEAD  = 4'd1;
  localparam logic [3:0] PH_ENDS  = 4'd2;
  localparam logic [3:0] PH_ILEN  = 4'd3;
  localparam logic [3:0] PH_ISKIP = 4'd4;
  localparam logic [3:0] PH_FLAG  = 4'd5;
  localparam logic [3:0] PH_REP   = 4'd6;
  localparam logic [3:0] PH_X     = 4'd7;
  localparam logic [3:0] PH_Y     = 4'd8;
  localparam logic [3:0] PH_READ  = 4'd9;
  localparam logic [3:0] PH_OVER  = 4'd10;

  typedef struct packed {
    logic         result_kind;
    logic [2:0]   status;
    logic [15:0]  min_x;
    logic [15:0]  min_y;
    logic [15:0]  max_x;
    logic [15:0]  max_y;
    logic [15:0]  point_x;
    logic [15:0]  point_y;
    logic         on_curve;
    logic         contour_end;
    logic         last_point;
  } result_t;

  // command from controller to datapath
  typedef struct packed {
    logic       start;     // begin an item in the datapath
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic    done;         // item finished
    logic    has_result;
    result_t res;
  } sts_t;

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'h7fff;
    if (v < -18'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/ttsg_ram.sv
`default_nettype none
module ttsg_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/ttsg_datapath.sv
`default_nettype none
module ttsg_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ttsg_pkg::cmd_t cmd_i,
  output ttsg_pkg::sts_t     sts_o
);
  import ttsg_pkg::*;

  // micro steps inside one item
  localparam logic [2:0] MS_IDLE = 3'd0;
  localparam logic [2:0] MS_RD   = 3'd1;  // wait on RAM read
  localparam logic [2:0] MS_EXEC = 3'd2;  // act on read data
  localparam logic [2:0] MS_REP  = 3'd3;  // write repeated flags
  localparam logic [2:0] MS_SKIP = 3'd4;  // wait on flag read of next point for zero-byte skip
  localparam logic [2:0] MS_SKW  = 3'd5;

  logic [2:0]  ms_q, ms_d;
  logic [3:0]  ph_q, ph_d;
  logic [15:0] bc_q, bc_d;
  logic [7:0]  hb_q, hb_d;
  logic [15:0] ct_q, ct_d;
  logic [PcW-1:0] pt_q, pt_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [CcW-1:0] cc_q, cc_d;
  logic [63:0] box_q, box_d;
  logic [15:0] prev_q, prev_d;     // previous coordinate
  logic [7:0]  rep_q, rep_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  db_q, db_d;
  logic        done_d, hasr_d;
  result_t     res_d;
  logic        done_q, hasr_q;
  result_t     res_q;

  // memories
  logic           fl_we, x_we, y_we, ce_we;
  logic [PtW-1:0] fl_wa, xy_wa, rd_a;
  logic [5:0]     fl_wd, fl_rd;
  logic [15:0]    xy_wd, x_rd, y_rd, ce_rd;
  logic [CtW-1:0] ce_wa, ce_ra;

  ttsg_ram #(.Width(6), .Depth(MaxPoints)) u_flag (
    .clk_i, .we_i(fl_we), .waddr_i(fl_wa), .wdata_i(fl_wd),
    .raddr_i(rd_a), .rdata_o(fl_rd));
  ttsg_ram #(.Width(16), .Depth(MaxPoints)) u_x (
    .clk_i, .we_i(x_we), .waddr_i(xy_wa), .wdata_i(xy_wd),
    .raddr_i(rd_a), .rdata_o(x_rd));
  ttsg_ram #(.Width(16), .Depth(MaxPoints)) u_y (
    .clk_i, .we_i(y_we), .waddr_i(xy_wa), .wdata_i(xy_wd),
    .raddr_i(rd_a), .rdata_o(y_rd));
  ttsg_ram #(.Width(16), .Depth(MaxContours)) u_ends (
    .clk_i, .we_i(ce_we), .waddr_i(ce_wa), .wdata_i({hb_q, db_q}),
    .raddr_i(ce_ra), .rdata_o(ce_rd));

  assign rd_a  = pc_q[PtW-1:0];
  assign ce_ra = cc_q[CtW-1:0];
  assign sts_o = '{done: done_q, has_result: hasr_q, res: res_q};

  logic [15:0]  v16;
  logic [PcW-1:0] remain;
  logic [1:0]   box_n;
  logic         sh, same, zskip;
  logic signed [17:0] delta, sum;
  logic [16:0]  v1;

  always_comb begin
    ms_d = ms_q; ph_d = ph_q; bc_d = bc_q; hb_d = hb_q; ct_d = ct_q;
    pt_d = pt_q; pc_d = pc_q; cc_d = cc_q; box_d = box_q; prev_d = prev_q;
    rep_d = rep_q; kind_d = kind_q; db_d = db_q;
    done_d = 1'b0; hasr_d = 1'b0; res_d = '0;
    fl_we = 1'b0; x_we = 1'b0; y_we = 1'b0; ce_we = 1'b0;
    fl_wa = pc_q[PtW-1:0]; xy_wa = pc_q[PtW-1:0]; fl_wd = db_q[5:0]; xy_wd = '0;
    ce_wa = bc_q[CtW:1];
    v16 = {hb_q, db_q};
    v1 = {1'b0, v16} + 17'd1;
    remain = pt_q - pc_q;
    box_n = 2'(({13'd0, bc_q[3:0]} - 17'd3) >> 1);
    sh = 1'b0; same = 1'b0; zskip = 1'b0;
    delta = '0;
    sum = '0;
    case (ms_q)
      MS_IDLE: begin
        if (cmd_i.start) begin
          kind_d = cmd_i.kind;
          db_d = cmd_i.data;
          ms_d = MS_RD;
        end
      end
      MS_RD: ms_d = MS_EXEC;
      MS_EXEC: begin
        ms_d = MS_IDLE;
        done_d = 1'b1;
        case (kind_q)
          KIND_START: begin
            ph_d = PH_HEAD; bc_d = '0; hb_d = '0; ct_d = '0; pt_d = '0;
            pc_d = '0; cc_d = '0; box_d = '0;
          end
          KIND_READ: begin
            hasr_d = 1'b1;
            if (ph_q != PH_READ || pc_q >= pt_q) begin
              res_d.status = ST_NOPOINT;
            end else begin
              res_d.result_kind = 1'b1;
              res_d.point_x = x_rd;
              res_d.point_y = y_rd;
              res_d.on_curve = fl_rd[0];
              if ({{(16-CcW){1'b0}}, cc_q} < ct_q && ce_rd == 16'(pc_q)) begin
                res_d.contour_end = 1'b1;
                cc_d = cc_q + 1'b1;
              end
              if (pc_q + 1'b1 == pt_q) begin
                res_d.contour_end = 1'b1;
                res_d.last_point = 1'b1;
              end
              pc_d = pc_q + 1'b1;
            end
          end
          KIND_BYTE: begin
            case (ph_q)
              PH_HEAD: begin
                if (!bc_q[0]) begin
                  hb_d = db_q; bc_d = bc_q + 1'b1;
                end else begin
                  if (bc_q == 16'd1) ct_d = v16;
                  else box_d[16*box_n +: 16] = v16;
                  bc_d = bc_q + 1'b1;
                  if (bc_q == 16'd9) begin
                    bc_d = '0;
                    ph_d = PH_OVER;
                    res_d.min_x = box_d[15:0]; res_d.min_y = box_d[31:16];
                    res_d.max_x = box_d[47:32]; res_d.max_y = box_d[63:48];
                    if (ct_q[15]) begin
                      hasr_d = 1'b1; res_d.status = ST_COMPOUND;
                    end else if (ct_q == 16'd0) begin
                      hasr_d = 1'b1; res_d.status = ST_EMPTY;
                    end else if (ct_q > 16'(MaxContours)) begin
                      hasr_d = 1'b1; res_d.status = ST_TOOLARGE;
                    end else begin
                      ph_d = PH_ENDS;
                    end
                  end
                end
              end
              PH_ENDS: begin
                if (!bc_q[0]) begin
                  hb_d = db_q; bc_d = bc_q + 1'b1;
                end else begin
                  ce_we = 1'b1;
                  bc_d = bc_q + 1'b1;
                  if ({1'b0, bc_q[15:1]} + 16'd1 >= ct_q) begin
                    bc_d = '0;
                    if (v1 > 17'(MaxPoints)) begin
                      ph_d = PH_OVER; hasr_d = 1'b1; res_d.status = ST_TOOLARGE;
                      res_d.min_x = box_q[15:0]; res_d.min_y = box_q[31:16];
                      res_d.max_x = box_q[47:32]; res_d.max_y = box_q[63:48];
                    end else begin
                      pt_d = PcW'(v1);
                      ph_d = PH_ILEN;
                    end
                  end
                end
              end
              PH_ILEN: begin
                if (bc_q == 16'd0) begin
                  hb_d = db_q; bc_d = 16'd1;
                end else begin
                  bc_d = v16; pc_d = '0;
                  ph_d = (v16 != 16'd0) ? PH_ISKIP : PH_FLAG;
                end
              end
              PH_ISKIP: begin
                bc_d = bc_q - 1'b1;
                if (bc_q == 16'd1) ph_d = PH_FLAG;
              end
              PH_FLAG: begin
                if (pc_q < pt_q) begin
                  fl_we = 1'b1; pc_d = pc_q + 1'b1;
                end
                hb_d = {2'b00, db_q[5:0]};
                if (db_q[3]) begin
                  ph_d = PH_REP;
                end else if (pc_d >= pt_q) begin
                  ph_d = PH_X; pc_d = '0; bc_d = '0; prev_d = '0;
                  done_d = 1'b0; ms_d = MS_SKIP;
                end
              end
              PH_REP: begin
                rep_d = ({{(PcW-8){1'b0}}, db_q} < remain) ? db_q : 8'(remain);
                ph_d = PH_FLAG;
                done_d = 1'b0; ms_d = MS_REP;
              end
              PH_X, PH_Y: begin
                if (ph_q == PH_X) begin
                  sh = fl_rd[1]; same = fl_rd[4];
                end else begin
                  sh = fl_rd[2]; same = fl_rd[5];
                end
                if (!sh && bc_q == 16'd0) begin
                  hb_d = db_q; bc_d = 16'd1;
                end else begin
                  if (sh) delta = same ? $signed({10'd0, db_q}) : -$signed({10'd0, db_q});
                  else delta = 18'($signed(v16));
                  sum = 18'($signed(prev_q)) + delta;
                  xy_wd = sat16(sum);
                  x_we = (ph_q == PH_X); y_we = (ph_q == PH_Y);
                  prev_d = xy_wd;
                  pc_d = pc_q + 1'b1; bc_d = '0;
                  done_d = 1'b0; ms_d = MS_SKIP;
                end
              end
              default: ;
            endcase
          end
          default: done_d = 1'b1;
        endcase
      end
      MS_REP: begin
        if (rep_q == 8'd0) begin
          if (pc_q >= pt_q) begin
            ph_d = PH_X; pc_d = '0; bc_d = '0; prev_d = '0;
            ms_d = MS_SKIP;
          end else begin
            done_d = 1'b1; ms_d = MS_IDLE;
          end
        end else begin
          fl_we = 1'b1; fl_wd = hb_q[5:0];
          pc_d = pc_q + 1'b1; rep_d = rep_q - 1'b1;
        end
      end
      MS_SKIP: ms_d = MS_SKW;   // flag read of new cursor in flight
      MS_SKW: begin
        if (pc_q >= pt_q) begin
          if (ph_q == PH_X) begin
            ph_d = PH_Y; pc_d = '0; bc_d = '0; prev_d = '0; ms_d = MS_SKIP;
          end else begin
            ph_d = PH_READ; pc_d = '0; cc_d = '0;
            ms_d = MS_IDLE; done_d = 1'b1; hasr_d = 1'b1;
            res_d.status = ST_DONE;
            res_d.min_x = box_q[15:0]; res_d.min_y = box_q[31:16];
            res_d.max_x = box_q[47:32]; res_d.max_y = box_q[63:48];
          end
        end else begin
          zskip = (ph_q == PH_X) ? (fl_rd[4] && !fl_rd[1]) : (fl_rd[5] && !fl_rd[2]);
          if (zskip) begin
            xy_wd = prev_q;
            x_we = (ph_q == PH_X); y_we = (ph_q == PH_Y);
            pc_d = pc_q + 1'b1; ms_d = MS_SKIP;
          end else begin
            ms_d = MS_IDLE; done_d = 1'b1;
          end
        end
      end
      default: ms_d = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= MS_IDLE; ph_q <= PH_IDLE; bc_q <= '0; hb_q <= '0; ct_q <= '0;
      pt_q <= '0; pc_q <= '0; cc_q <= '0; box_q <= '0; prev_q <= '0;
      rep_q <= '0; kind_q <= '0; db_q <= '0; done_q <= 1'b0; hasr_q <= 1'b0;
    end else begin
      ms_q <= ms_d; ph_q <= ph_d; bc_q <= bc_d; hb_q <= hb_d; ct_q <= ct_d;
      pt_q <= pt_d; pc_q <= pc_d; cc_q <= cc_d; box_q <= box_d; prev_q <= prev_d;
      rep_q <= rep_d; kind_q <= kind_d; db_q <= db_d; done_q <= done_d;
      hasr_q <= hasr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end
endmodule
`default_nettype wire

// File: rtl/ttsg_ctrl.sv
`default_nettype none
module ttsg_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_tvalid_i,
  output logic                s_tready_o,
  input  wire logic [7:0]     s_tdata_i,
  input  wire logic [1:0]     s_tuser_i,
  output logic                m_tvalid_o,
  input  wire logic           m_tready_i,
  output ttsg_pkg::result_t   m_res_o,
  output ttsg_pkg::cmd_t      cmd_o,
  input  wire ttsg_pkg::sts_t sts_i
);
  import ttsg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;

  logic [1:0] state_q, state_d;
  logic       ov_q, ov_d;
  result_t    out_q;
  logic       take;

  // the output register parts the sides; hold input while a result waits
  assign s_tready_o = (state_q == S_IDLE) && !ov_q;
  assign take       = s_tvalid_i && s_tready_o;
  assign cmd_o      = '{start: take, kind: s_tuser_i, data: s_tdata_i};
  assign m_tvalid_o = ov_q;
  assign m_res_o    = out_q;

  always_comb begin
    state_d = state_q;
    ov_d = ov_q && !m_tready_i;
    case (state_q)
      S_IDLE: if (take) state_d = S_BUSY;
      S_BUSY: begin
        if (sts_i.done) begin
          state_d = S_IDLE;
          if (sts_i.has_result) ov_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_BUSY && sts_i.done && sts_i.has_result) out_q <= sts_i.res;
  end
endmodule
`default_nettype wire

// File: rtl/truetype_simple_glyph_decode.sv
// Timing: a taken beat passes a RAM read step and an execute step in the datapath; the
// result is registered in the datapath status, then in the output register. A repeat count
// adds a write of each repeated flag; a stored coordinate, the last flag, each skipped
// zero-byte coordinate and the end of the x pass add a flag read and check. Flow: one beat
// at a time; the next beat is taken once its item is done and any result has been taken.
// Reset: rst_ni asynchronous, active low; clears the controller and parse state.
`default_nettype none
module truetype_simple_glyph_decode (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // data_byte[7:0]
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], min_x[18:3], min_y[34:19], max_x[50:35], max_y[66:51],
  // point_x[82:67], point_y[98:83], on_curve[99], contour_end[100], zero fill
  output logic [103:0]     m_axis_tdata,
  output logic             m_axis_tuser,  // result_kind[0]
  output logic             m_axis_tlast   // last_point
);
  import ttsg_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  result_t r;

  ttsg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .s_tuser_i(s_axis_tuser),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_res_o(r),
    .cmd_o(cmd), .sts_i(sts));

  ttsg_datapath u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts));

  assign m_axis_tdata = {3'b000, r.contour_end, r.on_curve, r.point_y, r.point_x,
                         r.max_y, r.max_x, r.min_y, r.min_x, r.status};
  assign m_axis_tuser = r.result_kind;
  assign m_axis_tlast = r.last_point;
endmodule
`default_nettype wire

// File: rtl/ttsg_checker.sv
`default_nettype none
module ttsg_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [103:0] m_axis_tdata,
  input wire logic         m_axis_tuser,
  input wire logic         m_axis_tlast
);
  import ttsg_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_noready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result waits");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken back to back");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[2:0] <= ST_NOPOINT)
    else $error("bad status code");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last mark on a status beat");
endmodule

bind truetype_simple_glyph_decode ttsg_checker u_chk (.*);
`default_nettype wire

// File: dv/tb_truetype_simple_glyph_decode.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_truetype_simple_glyph_decode;
  import ttsg_pkg::*;

  typedef struct {
    bit         drain;
    logic [1:0] kind;
    logic [7:0] data;
  } beat_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  truetype_simple_glyph_decode u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  beat_t   pending_q[$];
  result_t decoded_q[$];
  int      mismatches = 0;

  // decoder shadow state
  logic [3:0]  sh_phase = PH_IDLE;
  int unsigned sh_cnt = 0, sh_hold = 0, sh_contours = 0, sh_points = 0;
  int unsigned sh_pcur = 0, sh_ccur = 0;
  logic [63:0] sh_box = '0;
  logic [15:0] sh_ends [MaxContours];
  logic [5:0]  sh_flags [MaxPoints];
  logic [15:0] sh_xs [MaxPoints];
  logic [15:0] sh_ys [MaxPoints];

  function automatic result_t status_res(logic [2:0] code, bit with_box);
    result_t r;
    r = '0;
    r.status = code;
    if (with_box) begin
      r.min_x = sh_box[15:0];
      r.min_y = sh_box[31:16];
      r.max_x = sh_box[47:32];
      r.max_y = sh_box[63:48];
    end
    return r;
  endfunction

  task automatic put_coord(bit is_y, int delta);
    int prev, sum;
    prev = 0;
    if (sh_pcur != 0)
      prev = is_y ? int'($signed(sh_ys[sh_pcur-1])) : int'($signed(sh_xs[sh_pcur-1]));
    sum = prev + delta;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    if (is_y) sh_ys[sh_pcur] = sum[15:0];
    else sh_xs[sh_pcur] = sum[15:0];
    sh_pcur++;
    sh_cnt = 0;
  endtask

  // consume coordinates that take no byte; return 1 when the glyph is complete
  task automatic skip_empty_coords(output bit complete);
    complete = 0;
    if (sh_phase == PH_X) begin
      while (sh_pcur < sh_points && (sh_flags[sh_pcur] & 6'h12) == 6'h10) put_coord(0, 0);
      if (sh_pcur < sh_points) return;
      sh_phase = PH_Y;
      sh_pcur = 0;
      sh_cnt = 0;
    end
    if (sh_phase == PH_Y) begin
      while (sh_pcur < sh_points && (sh_flags[sh_pcur] & 6'h24) == 6'h20) put_coord(1, 0);
      if (sh_pcur < sh_points) return;
      sh_phase = PH_READ;
      sh_pcur = 0;
      sh_ccur = 0;
      complete = 1;
    end
  endtask

  task automatic decode_beat(logic [1:0] kind, logic [7:0] b, output bit has,
                             output result_t r);
    int unsigned v, n;
    bit is_y, complete, after_flag;
    logic [5:0] f;
    has = 0;
    r = '0;
    after_flag = 0;
    if (kind == KIND_START) begin
      sh_phase = PH_HEAD;
      sh_cnt = 0; sh_hold = 0; sh_contours = 0; sh_points = 0;
      sh_pcur = 0; sh_ccur = 0; sh_box = '0;
      return;
    end
    if (kind == KIND_READ) begin
      has = 1;
      if (sh_phase != PH_READ || sh_pcur >= sh_points || sh_pcur >= MaxPoints) begin
        r = status_res(ST_NOPOINT, 0);
        return;
      end
      r.result_kind = 1'b1;
      r.point_x = sh_xs[sh_pcur];
      r.point_y = sh_ys[sh_pcur];
      r.on_curve = sh_flags[sh_pcur][0];
      if (sh_ccur < sh_contours && sh_ccur < MaxContours && sh_ends[sh_ccur] == sh_pcur) begin
        r.contour_end = 1'b1;
        sh_ccur++;
      end
      if (sh_pcur + 1 == sh_points) begin
        r.contour_end = 1'b1;
        r.last_point = 1'b1;
      end
      sh_pcur++;
      return;
    end
    if (kind != KIND_BYTE) return;
    case (sh_phase)
      PH_HEAD: begin
        if (sh_cnt[0] == 1'b0) begin
          sh_hold = b;
          sh_cnt++;
          return;
        end
        v = (sh_hold << 8) | b;
        if (sh_cnt == 1) sh_contours = v;
        else begin
          n = (sh_cnt - 3) >> 1;
          sh_box[16*n +: 16] = v[15:0];
        end
        sh_cnt++;
        if (sh_cnt < 10) return;
        sh_cnt = 0;
        sh_phase = PH_OVER;
        has = 1;
        if (sh_contours[15]) r = status_res(ST_COMPOUND, 1);
        else if (sh_contours == 0) r = status_res(ST_EMPTY, 1);
        else if (sh_contours > MaxContours) r = status_res(ST_TOOLARGE, 1);
        else begin
          has = 0;
          sh_phase = PH_ENDS;
        end
      end
      PH_ENDS: begin
        if (sh_cnt[0] == 1'b0) begin
          sh_hold = b;
          sh_cnt++;
          return;
        end
        v = (sh_hold << 8) | b;
        n = sh_cnt >> 1;
        if (n < MaxContours) sh_ends[n] = v[15:0];
        sh_cnt++;
        if (n + 1 < sh_contours) return;
        sh_cnt = 0;
        if (v + 1 > MaxPoints) begin
          sh_phase = PH_OVER;
          has = 1;
          r = status_res(ST_TOOLARGE, 1);
          return;
        end
        sh_points = v + 1;
        sh_phase = PH_ILEN;
      end
      PH_ILEN: begin
        if (sh_cnt == 0) begin
          sh_hold = b;
          sh_cnt = 1;
          return;
        end
        v = (sh_hold << 8) | b;
        sh_cnt = v;
        sh_pcur = 0;
        sh_phase = (v != 0) ? PH_ISKIP : PH_FLAG;
      end
      PH_ISKIP: begin
        sh_cnt--;
        if (sh_cnt == 0) sh_phase = PH_FLAG;
      end
      PH_FLAG: begin
        if (sh_pcur < sh_points) begin
          sh_flags[sh_pcur] = b[5:0];
          sh_pcur++;
        end
        sh_hold = b[5:0];
        if (b[3]) sh_phase = PH_REP;
        else after_flag = 1;
      end
      PH_REP: begin
        n = sh_points - sh_pcur;
        if (b < n) n = b;
        repeat (n) begin
          sh_flags[sh_pcur] = sh_hold[5:0];
          sh_pcur++;
        end
        sh_phase = PH_FLAG;
        after_flag = 1;
      end
      PH_X, PH_Y: begin
        is_y = (sh_phase == PH_Y);
        f = sh_flags[sh_pcur];
        if (is_y ? f[2] : f[1]) begin
          put_coord(is_y, (is_y ? f[5] : f[4]) ? int'(b) : -int'(b));
        end else if (sh_cnt == 0) begin
          sh_hold = b;
          sh_cnt = 1;
          return;
        end else begin
          v = (sh_hold << 8) | b;
          put_coord(is_y, int'($signed(v[15:0])));
        end
        skip_empty_coords(complete);
        if (complete) begin
          has = 1;
          r = status_res(ST_DONE, 1);
        end
      end
      default: ;
    endcase
    if (after_flag && sh_pcur >= sh_points) begin
      sh_phase = PH_X;
      sh_pcur = 0;
      sh_cnt = 0;
      skip_empty_coords(complete);
      if (complete) begin
        has = 1;
        r = status_res(ST_DONE, 1);
      end
    end
  endtask

  task automatic report(string field, longint got, longint want);
    if (got != want) begin
      mismatches++;
      $display("%0t: %s got %0h want %0h", $time, field, got, want);
    end
  endtask

  // sample: accept input beats and check output beats
  always @(posedge clk_i) begin
    bit      has;
    result_t r, want;
    if (s_axis_tvalid && s_axis_tready) begin
      decode_beat(s_axis_tuser, s_axis_tdata, has, r);
      if (has) decoded_q.push_back(r);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output beat %h", $time, m_axis_tdata);
      end else begin
        want = decoded_q.pop_front();
        report("result_kind", m_axis_tuser, want.result_kind);
        report("status", m_axis_tdata[2:0], want.status);
        report("min_x", m_axis_tdata[18:3], want.min_x);
        report("min_y", m_axis_tdata[34:19], want.min_y);
        report("max_x", m_axis_tdata[50:35], want.max_x);
        report("max_y", m_axis_tdata[66:51], want.max_y);
        report("point_x", m_axis_tdata[82:67], want.point_x);
        report("point_y", m_axis_tdata[98:83], want.point_y);
        report("on_curve", m_axis_tdata[99], want.on_curve);
        report("contour_end", m_axis_tdata[100], want.contour_end);
        report("last_point", m_axis_tlast, want.last_point);
      end
    end
  end

  // sender: bursts and gaps, drive at the falling edge
  int burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    beat_t nb;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) s_axis_tvalid = 1'b0;
      if (!s_axis_tvalid) begin
        if (gap_left > 0) gap_left--;
        else if (pending_q.size() != 0) begin
          nb = pending_q[0];
          if (nb.drain) begin
            // hold until every outstanding result has been seen
            if (decoded_q.size() == 0) void'(pending_q.pop_front());
          end else begin
            void'(pending_q.pop_front());
            s_axis_tdata = nb.data;
            s_axis_tuser = nb.kind;
            s_axis_tvalid = 1'b1;
            if (burst_left > 0) burst_left--;
            else begin
              burst_left = $urandom_range(0, 20);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        end
      end
    end
  end

  // receiver: stall pattern switches among three random modes: always, mostly or rarely ready
  int rx_cycle = 0;
  int rx_mode = 0;
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = ($urandom_range(0, 3) != 0);
      default: m_axis_tready = ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic add(logic [1:0] kind, logic [7:0] data);
    beat_t nb;
    nb.drain = 0;
    nb.kind = kind;
    nb.data = data;
    pending_q.push_back(nb);
  endtask

  task automatic add_word(logic [15:0] w);
    add(KIND_BYTE, w[15:8]);
    add(KIND_BYTE, w[7:0]);
  endtask

  task automatic add_drain();
    beat_t nb;
    nb.drain = 1;
    nb.kind = KIND_START;
    nb.data = '0;
    pending_q.push_back(nb);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // one glyph record, mostly well formed, sometimes rejected or cut short
  task automatic add_glyph();
    logic [7:0]  rec[$];
    logic [5:0]  pf[$];
    logic [15:0] cnt, e;
    int mode, npts, covered, r, ilen, cut;
    logic [7:0]  f;
    mode = $urandom_range(0, 19);
    case (mode)
      0: cnt = 16'h8000 | 16'($urandom);
      1: cnt = 0;
      2: cnt = 16'(MaxContours + 1 + $urandom_range(0, 2000));
      default: cnt = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 12)
                                                      : $urandom_range(1, 3));
    endcase
    add(KIND_START, 8'($urandom));
    rec.push_back(cnt[15:8]);
    rec.push_back(cnt[7:0]);
    repeat (4) begin
      e = rand_coord();
      rec.push_back(e[15:8]);
      rec.push_back(e[7:0]);
    end
    if (mode < 3) begin
      foreach (rec[i]) add(KIND_BYTE, rec[i]);
      repeat ($urandom_range(0, 2)) add(KIND_BYTE, 8'($urandom));
      add(KIND_READ, 8'($urandom));
      return;
    end
    npts = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
    if (npts < cnt) npts = cnt;
    if (mode == 3) npts = MaxPoints + 1 + $urandom_range(0, 100);
    e = 0;
    for (int i = 0; i < cnt; i++) begin
      if (i == cnt - 1) e = 16'(npts - 1);
      else if (i != 0) e = 16'(e + $urandom_range(0, 3));
      if (e > npts - 1) e = 16'(npts - 1);
      rec.push_back(e[15:8]);
      rec.push_back(e[7:0]);
    end
    if (mode == 3) begin
      foreach (rec[i]) add(KIND_BYTE, rec[i]);
      add(KIND_READ, 8'($urandom));
      return;
    end
    ilen = $urandom_range(0, 3);
    rec.push_back(8'(ilen >> 8));
    rec.push_back(8'(ilen));
    repeat (ilen) rec.push_back(8'($urandom));
    covered = 0;
    while (covered < npts) begin
      f = 8'($urandom);
      if ($urandom_range(0, 2) != 0) f[3] = 1'b0;
      rec.push_back(f);
      pf.push_back(f[5:0]);
      covered++;
      if (f[3]) begin
        r = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
        rec.push_back(8'(r));
        for (int k = 0; k < r && covered < npts; k++) begin
          pf.push_back(f[5:0]);
          covered++;
        end
      end
    end
    for (int axis = 0; axis < 2; axis++) begin
      foreach (pf[i]) begin
        e = rand_coord();
        if (axis == 0 ? pf[i][1] : pf[i][2]) rec.push_back(e[7:0]);
        else if (!(axis == 0 ? pf[i][4] : pf[i][5])) begin
          rec.push_back(e[15:8]);
          rec.push_back(e[7:0]);
        end
      end
    end
    cut = rec.size();
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, rec.size());
    for (int i = 0; i < cut; i++) begin
      add(KIND_BYTE, rec[i]);
      // early read while still parsing
      if ($urandom_range(0, 40) == 0) add(KIND_READ, 8'($urandom));
    end
    repeat (npts + $urandom_range(0, 1)) add(KIND_READ, 8'($urandom));
  endtask

  initial begin
    int glyphs;
    // directed: stray beats while idle, then a compound header with extreme box
    add(KIND_READ, 8'h00);
    add(KIND_NOP, 8'hff);
    add(KIND_BYTE, 8'hff);
    add(KIND_BYTE, 8'h00);
    add(KIND_START, 8'h00);
    add_word(16'hffff);
    add_word(16'h8000);
    add_word(16'h7fff);
    add_word(16'h8000);
    add_word(16'h7fff);
    add(KIND_READ, 8'hff);
    add(KIND_BYTE, 8'h55);
    add(KIND_START, 8'haa);
    add(KIND_NOP, 8'h00);
    add_drain();
    glyphs = 0;
    while (pending_q.size() < 515) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) add(2'($urandom), 8'($urandom));
      end else begin
        add_glyph();
        glyphs++;
        if (glyphs % 4 == 0) add_drain();
      end
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_q.size() == 0 && !s_axis_tvalid && decoded_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && decoded_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
